FILE: src/bpm_pkg.sv
// Package for the BCD peasant multiplier: field widths, defaults, sequencer
// state type and the control struct between the sequencer and the datapath.
// No dependencies.
`default_nettype none
package bpm_pkg;

  // Default operand width in decimal digits
  localparam int DIGITS_DEF = 8;

  // Fixed widths of the stream fields
  localparam int OPND_W   = 32;
  localparam int PROD_W   = 64;
  localparam int CNT_W    = 5;
  localparam int IN_TD_W  = 2 * OPND_W;
  localparam int OUT_FD_W = PROD_W + CNT_W + 1;
  localparam int OUT_TD_W = ((OUT_FD_W + 7) / 8) * 8;

  // Largest value one BCD digit may hold
  localparam logic [3:0] BCD_MAX = 4'd9;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bpm_state_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic load;  // take fresh operands, clear the accumulator
    logic step;  // run one add/halve/double iteration
  } bpm_ctrl_t;

endpackage
`default_nettype wire

FILE: src/bpm_bcd_adder.sv
// Packed-BCD adder: one binary add with a +6 bias per digit, then a per-digit
// correction where no decimal carry left the digit. Carry out of the top
// digit is dropped. No dependencies.
`default_nettype none
module bpm_bcd_adder #(
  parameter int NDIG = 16
) (
  input  wire logic [4*NDIG-1:0] a,
  input  wire logic [4*NDIG-1:0] b,
  output logic      [4*NDIG-1:0] sum
);

  localparam int W = 4 * NDIG;
  localparam logic [W-1:0] SIX = {NDIG{4'h6}};

  logic [W:0] xa;
  logic [W:0] xb;
  logic [W:0] t;

  assign xa = {1'b0, a};
  assign xb = {1'b0, b};
  assign t  = xa + xb + {1'b0, SIX};

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      // decimal carry out of digit i, recovered from the binary carry into bit 4i+4
      if (t[4*i+4] ^ xa[4*i+4] ^ xb[4*i+4]) begin
        sum[4*i +: 4] = t[4*i +: 4];
      end else begin
        sum[4*i +: 4] = t[4*i +: 4] - 4'd6;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/bpm_datapath.sv
// Working registers of the peasant loop: multiplier, multiplicand and
// accumulator, with one decimal halve, double and add per step.
// Depends on bpm_pkg and bpm_bcd_adder.
`default_nettype none
module bpm_datapath #(
  parameter int DIGITS = bpm_pkg::DIGITS_DEF
) (
  input  wire logic                     clk,
  input  wire bpm_pkg::bpm_ctrl_t       ctrl,
  input  wire logic [4*DIGITS-1:0]      mult_in,
  input  wire logic [4*DIGITS-1:0]      cand_in,
  output logic                          mult_zero,
  output logic      [8*DIGITS-1:0]      acc
);

  localparam int MW = 4 * DIGITS;
  localparam int AW = 8 * DIGITS;
  localparam int CW = 4 * (2 * DIGITS + 1);

  logic [MW-1:0] mult_r, mult_half;
  logic [MW+3:0] mult_ext;
  logic [CW-1:0] cand_r, cand_dbl;
  logic [AW-1:0] acc_r, acc_sum;

  // a zero digit above the top one, so every digit sees a neighbour
  assign mult_ext = {4'd0, mult_r};

  // Halve: each digit shifts right, picking up five from an odd digit above
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      mult_half[4*i +: 4] = {1'b0, mult_ext[4*i+1 +: 3]}
                            + (mult_ext[4*i+4] ? 4'd5 : 4'd0);
    end
  end

  bpm_bcd_adder #(.NDIG(2 * DIGITS)) u_acc_add (
    .a   (acc_r),
    .b   (cand_r[AW-1:0]),
    .sum (acc_sum)
  );

  bpm_bcd_adder #(.NDIG(2 * DIGITS + 1)) u_cand_dbl (
    .a   (cand_r),
    .b   (cand_r),
    .sum (cand_dbl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mult_r <= mult_in;
      cand_r <= {{(CW - MW){1'b0}}, cand_in};
      acc_r  <= '0;
    end else if (ctrl.step) begin
      if (mult_r[0]) begin
        acc_r <= acc_sum;
      end
      mult_r <= mult_half;
      cand_r <= cand_dbl;
    end
  end

  assign mult_zero = (mult_r == '0);
  assign acc       = acc_r;

endmodule
`default_nettype wire

FILE: src/bcd_peasant_multiplier_core.sv
// Top level of the decimal peasant multiplier: stream ports, sequencer,
// digit check, significant-digit count and output register.
// Depends on bpm_pkg and bpm_datapath.
//
// Usage:
//   Offer a request on the in_ channel: in_tdata carries the multiplier in
//   the low 32 bits and the multiplicand in the high 32 bits, both packed BCD
//   with the least significant digit in the lowest nibble. Only the low
//   DIGITS nibbles are used and checked.
//   The block takes one request at a time; in_tready is high only while the
//   sequencer is idle. Each step of the loop halves the multiplier, doubles
//   the multiplicand and adds it into the accumulator when the multiplier
//   is odd, all in the same cycle, through separate BCD adders.
//   The loop runs until the multiplier reaches zero; a new request is
//   taken only after the result has gone to the output register and the
//   sequencer is back in idle. A zero multiplier or a bad digit ends the
//   loop before any step.
//   A digit above 9 gives bad_digit set, a zero product and a count of one.
//   The result sits in an output register; if the receiver stalls, the
//   finished product waits in the accumulator until the register frees,
//   and no new request is taken meanwhile.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any result held in the output register.
`default_nettype none
module bcd_peasant_multiplier_core #(
  parameter int DIGITS = bpm_pkg::DIGITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [31:0] multiplier_bcd, [63:32] multiplicand_bcd
  input  wire logic [bpm_pkg::IN_TD_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [63:0] product_bcd, [68:64] product_digits, [69] bad_digit, [71:70] zero
  output logic      [bpm_pkg::OUT_TD_W-1:0] out_tdata
);

  localparam int MW = 4 * DIGITS;
  localparam int AW = 8 * DIGITS;
  localparam int PW = bpm_pkg::PROD_W;
  localparam int CW = bpm_pkg::CNT_W;

  bpm_pkg::bpm_state_t state_r, state_nxt;
  bpm_pkg::bpm_ctrl_t  ctrl;

  logic                              bad_r, bad_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [bpm_pkg::OUT_TD_W-1:0]      out_tdata_r, out_tdata_nxt;

  logic [MW-1:0] mult_op, cand_op;
  logic          in_bad;
  logic          mult_zero;
  logic [AW-1:0] acc;
  logic [CW-1:0] sig_cnt;
  logic          out_free;
  logic          accept;

  // Check the used digits of both operands
  always_comb begin
    in_bad = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (in_tdata[4*i +: 4] > bpm_pkg::BCD_MAX ||
          in_tdata[bpm_pkg::OPND_W + 4*i +: 4] > bpm_pkg::BCD_MAX) begin
        in_bad = 1'b1;
      end
    end
  end

  // A bad request runs with zero operands, so the loop ends at once
  assign mult_op = in_bad ? '0 : in_tdata[MW-1:0];
  assign cand_op = in_bad ? '0 : in_tdata[bpm_pkg::OPND_W +: MW];

  bpm_datapath #(.DIGITS(DIGITS)) u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .mult_in   (mult_op),
    .cand_in   (cand_op),
    .mult_zero (mult_zero),
    .acc       (acc)
  );

  // Count significant digits: highest nonzero digit, at least one
  always_comb begin
    sig_cnt = CW'(1);
    for (int i = 0; i < 2 * DIGITS; i++) begin
      if (acc[4*i +: 4] != 4'd0) begin
        sig_cnt = CW'(i + 1);
      end
    end
  end

  assign in_tready = (state_r == bpm_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    bad_nxt        = bad_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ctrl.load      = 1'b0;
    ctrl.step      = 1'b0;

    // drop the registered result once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      bpm_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          bad_nxt   = in_bad;
          state_nxt = bpm_pkg::ST_RUN;
        end
      end
      bpm_pkg::ST_RUN: begin
        if (!mult_zero) begin
          ctrl.step = 1'b1;
        end else if (out_free) begin
          // hand the finished product to the output register
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tdata_nxt[PW-1:0]       = PW'(acc);
          out_tdata_nxt[PW +: CW]     = sig_cnt;
          out_tdata_nxt[PW + CW]      = bad_r;
          state_nxt      = bpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpm_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bad_r       <= bad_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

FILE: test/bcd_peasant_multiplier_core_test.sv
// Self-checking testbench for bcd_peasant_multiplier_core: directed and random
// packed-BCD multiplications, checked against a binary-arithmetic product model.
// Depends on bpm_pkg and the block under test only.
`default_nettype none
module bcd_peasant_multiplier_core_test;
  import bpm_pkg::*;

  localparam int NUM_DIGITS    = DIGITS_DEF;
  localparam int RANDOM_ITEMS  = 700;
  localparam int LONG_HOLD     = 300;   // receiver hold-off, cycles
  localparam int DRAIN_CYCLES  = 40;    // wait for strays after the last product
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake

  typedef struct {
    logic [PROD_W-1:0] product;
    logic [CNT_W-1:0]  digits;
    logic              bad;
  } bcd_product_t;

  // Work out the decimal product in binary and convert it back to BCD.
  function automatic bcd_product_t multiply_bcd(logic [OPND_W-1:0] mplr,
                                                logic [OPND_W-1:0] mcnd);
    bcd_product_t    res;
    longint unsigned a;
    longint unsigned b;
    longint unsigned p;
    int              i;
    res.product = '0;
    res.digits  = CNT_W'(1);
    res.bad     = 1'b0;
    a = 0;
    b = 0;
    for (i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (mplr[4*i +: 4] > BCD_MAX || mcnd[4*i +: 4] > BCD_MAX) res.bad = 1'b1;
      a = a * 10 + mplr[4*i +: 4];
      b = b * 10 + mcnd[4*i +: 4];
    end
    if (!res.bad) begin
      p = a * b;
      for (i = 0; i < 2 * NUM_DIGITS; i++) begin
        res.product[4*i +: 4] = 4'(p % 10);
        if (p % 10 != 0) res.digits = CNT_W'(i + 1);
        p = p / 10;
      end
    end
    return res;
  endfunction

  // Holds the products still owed by the block, oldest first.
  class product_ledger;
    bcd_product_t awaited_products[$];
    int           errors;
    int           requests;
    int           results;
    int           bad_results;

    function new();
      errors      = 0;
      requests    = 0;
      results     = 0;
      bad_results = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void note_request(logic [OPND_W-1:0] mplr, logic [OPND_W-1:0] mcnd);
      awaited_products.push_back(multiply_bcd(mplr, mcnd));
      requests++;
    endfunction

    task check_result(logic [OUT_TD_W-1:0] word);
      bcd_product_t want;
      logic [PROD_W-1:0] got_product;
      logic [CNT_W-1:0]  got_digits;
      logic              got_bad;
      got_product = word[PROD_W-1:0];
      got_digits  = word[PROD_W +: CNT_W];
      got_bad     = word[PROD_W + CNT_W];
      results++;
      if (awaited_products.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", word));
      end else begin
        want = awaited_products.pop_front();
        if (want.bad) bad_results++;
        if (got_product !== want.product)
          report_mismatch($sformatf("product_bcd %h, want %h", got_product, want.product));
        if (got_digits !== want.digits)
          report_mismatch($sformatf("product_digits %0d, want %0d (product %h)",
                                    got_digits, want.digits, want.product));
        if (got_bad !== want.bad)
          report_mismatch($sformatf("bad_digit %b, want %b", got_bad, want.bad));
        if ((word >> OUT_FD_W) != 0)
          report_mismatch($sformatf("padding bits not zero in %h", word));
      end
    endtask

    function int pending();
      return awaited_products.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TD_W-1:0] out_tdata;

  product_ledger ledger;
  bit            hold_output = 1'b0;  // ask the receiver for one long hold-off
  bit            no_gaps     = 1'b0;  // both sides run flat out while set
  int            idle_cycles = 0;

  always #6 clk = ~clk;

  bcd_peasant_multiplier_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Fill the low n digits with random decimal digits, leave the rest zero.
  function automatic logic [OPND_W-1:0] random_bcd(int n);
    logic [OPND_W-1:0] v;
    int i;
    v = '0;
    for (i = 0; i < n; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // Offer one request from a falling edge and hold it until it is taken;
  // return on the falling edge after acceptance.
  task automatic send_request(input logic [OPND_W-1:0] mplr,
                              input logic [OPND_W-1:0] mcnd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};  // junk while idle
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mcnd, mplr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sample both handshakes at the rising edge and feed the ledger.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        ledger.note_request(in_tdata[OPND_W-1:0], in_tdata[IN_TD_W-1:OPND_W]);
      if (out_tvalid && out_tready)
        ledger.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: give up once nothing has moved for too long.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, bursts of readiness, and one long hold-off on
  // request so that the block fills up and drops in_tready.
  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [OPND_W-1:0] mplr;
    logic [OPND_W-1:0] mcnd;
    int                n;
    int                kind;
    int                pos;
    ledger    = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero operands, ones, the largest operands, carries across
    // every digit, and bad digits at either end of either operand.
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h9999_9999);
    send_request(32'h9999_9999, 32'h0000_0000);
    send_request(32'h0000_0001, 32'h0000_0001);
    send_request(32'h0000_0001, 32'h9999_9999);
    send_request(32'h9999_9999, 32'h0000_0001);
    send_request(32'h9999_9999, 32'h9999_9999);
    send_request(32'h0000_0002, 32'h0000_0005);
    send_request(32'h0000_0009, 32'h0000_0009);
    send_request(32'h1234_5678, 32'h8765_4321);
    send_request(32'h5000_0000, 32'h0000_0002);
    send_request(32'h1000_0000, 32'h1000_0000);
    send_request(32'h6710_8864, 32'h9876_5432);
    send_request(32'h8888_8888, 32'h5555_5555);
    send_request(32'h0000_000a, 32'h0000_0003);
    send_request(32'h0000_0003, 32'hf000_0000);
    send_request(32'ha000_0001, 32'h0000_0003);
    send_request(32'h0000_0007, 32'h0000_000f);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'h0000_0000, 32'ha000_0000);  // zero multiplier, bad digit
    send_request(32'hb000_0000, 32'h0000_0000);  // bad digit, zero multiplicand
    send_request(32'h9999_999c, 32'h9999_9999);

    // Random: mostly well-formed operands of varied length, some bad digits,
    // some zeros. Hold the receiver off once, run one stretch without gaps.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) hold_output = 1'b1;
      no_gaps = (n >= 450 && n < 530);
      mplr = random_bcd(($urandom_range(0, 3) == 0) ? NUM_DIGITS
                                                     : $urandom_range(1, NUM_DIGITS));
      mcnd = random_bcd(($urandom_range(0, 3) == 0) ? NUM_DIGITS
                                                     : $urandom_range(1, NUM_DIGITS));
      kind = $urandom_range(0, 19);
      pos  = $urandom_range(0, NUM_DIGITS - 1);
      case (kind)
        0: mplr = $urandom;
        1: mcnd = $urandom;
        2: mplr[4*pos +: 4] = 4'($urandom_range(10, 15));
        3: mcnd[4*pos +: 4] = 4'($urandom_range(10, 15));
        4: mplr = '0;
        5: mcnd = '0;
        default: ;
      endcase
      send_request(mplr, mcnd);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every owed product, then watch for strays.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d multiplications and %0d products, %0d with a bad digit,",
             ledger.requests, ledger.results, ledger.bad_results);
    $display("with random stalls on both sides and one %0d-cycle receiver hold-off.",
             LONG_HOLD);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
src/bpm_pkg.sv
src/bpm_bcd_adder.sv
src/bpm_datapath.sv
src/bcd_peasant_multiplier_core.sv
test/bcd_peasant_multiplier_core_test.sv
